/* hw/rtl/uft_pkg.sv */
// Shared types and constants of the UDP flow table.
package uft_pkg;

    localparam int TABLE_ENTRIES_DEF = 128;
    localparam int OUTCOME_W = 2;
    localparam int SLOT_W = 7;
    localparam int TIMEOUT_W = 16;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd30;

    localparam logic [OUTCOME_W-1:0] OUTCOME_HIT     = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUTCOME_NEW     = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUTCOME_FULL    = 2'd2;
    localparam logic [OUTCOME_W-1:0] OUTCOME_CLEARED = 2'd3;

    typedef struct packed {
        logic        clear;
        logic [31:0] address;
        logic [15:0] port;
        logic [31:0] now;
        logic [31:0] fresh;
    } req_t;

    typedef struct packed {
        logic [OUTCOME_W-1:0] outcome;
        logic [SLOT_W-1:0]    slot;
    } rsp_t;

endpackage

/* hw/rtl/uft_scan.sv */
// Session memory with the scan, claim and clear sequencer.
module uft_scan #(
    parameter int TABLE_ENTRIES = uft_pkg::TABLE_ENTRIES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  uft_pkg::req_t req,
    output logic          idle,
    output logic          done_valid,
    input  logic          done_ready,
    output uft_pkg::rsp_t rsp
);
    import uft_pkg::*;

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int CW = AW + 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ENTRIES - 1);
    localparam logic [CW-1:0] CNT_END = CW'(TABLE_ENTRIES);

    localparam logic [2:0] ST_INIT  = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_WRITE = 3'd3;
    localparam logic [2:0] ST_CLEAR = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    typedef struct packed {
        logic        valid;
        logic [31:0] expiry;
        logic [31:0] address;
        logic [15:0] port;
    } entry_t;

    entry_t mem [TABLE_ENTRIES];
    entry_t rd_data_reg;

    logic [2:0]           state_reg, state_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 chk_valid_reg, chk_valid_next;
    logic [AW-1:0]        chk_idx_reg, chk_idx_next;
    logic                 have_free_reg, have_free_next;
    logic [AW-1:0]        free_slot_reg, free_slot_next;
    logic [AW-1:0]        slot_reg, slot_next;
    logic [OUTCOME_W-1:0] outcome_reg, outcome_next;
    req_t                 req_reg;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    entry_t        wr_data;
    logic          live;
    logic          match;
    logic [31:0]   slot_wide;

    assign rd_en   = (state_reg == ST_SCAN) && (cnt_reg != CNT_END);
    assign rd_addr = cnt_reg[AW-1:0];

    // Data of the previous read is checked here while the next read is in flight.
    assign live  = rd_data_reg.valid && (rd_data_reg.expiry >= req_reg.now);
    assign match = live && (rd_data_reg.address == req_reg.address)
                        && (rd_data_reg.port == req_reg.port);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = cnt_reg[AW-1:0];
        wr_data = '0;
        if (state_reg == ST_WRITE)
        begin
            wr_en   = 1'b1;
            wr_addr = slot_reg;
            wr_data = '{valid: 1'b1, expiry: req_reg.fresh,
                        address: req_reg.address, port: req_reg.port};
        end
        else if ((state_reg == ST_INIT) || (state_reg == ST_CLEAR))
        begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            req_reg <= req;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        chk_valid_next = rd_en;
        chk_idx_next   = cnt_reg[AW-1:0];
        have_free_next = have_free_reg;
        free_slot_next = free_slot_reg;
        slot_next      = slot_reg;
        outcome_next   = outcome_reg;
        if (rd_en)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        unique case (state_reg)
            ST_INIT, ST_CLEAR:
            begin
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg[AW-1:0] == LAST_IDX)
                begin
                    if (state_reg == ST_INIT)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next   = ST_DONE;
                        outcome_next = OUTCOME_CLEARED;
                        slot_next    = '0;
                    end
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cnt_next       = '0;
                    chk_valid_next = 1'b0;
                    have_free_next = 1'b0;
                    free_slot_next = '0;
                    state_next     = req.clear ? ST_CLEAR : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (chk_valid_reg)
                begin
                    if (match)
                    begin
                        slot_next    = chk_idx_reg;
                        outcome_next = OUTCOME_HIT;
                        state_next   = ST_WRITE;
                    end
                    else
                    begin
                        if (!live && !have_free_reg)
                        begin
                            have_free_next = 1'b1;
                            free_slot_next = chk_idx_reg;
                        end
                        if (chk_idx_reg == LAST_IDX)
                        begin
                            if (have_free_reg)
                            begin
                                slot_next    = free_slot_reg;
                                outcome_next = OUTCOME_NEW;
                                state_next   = ST_WRITE;
                            end
                            else if (!live)
                            begin
                                slot_next    = chk_idx_reg;
                                outcome_next = OUTCOME_NEW;
                                state_next   = ST_WRITE;
                            end
                            else
                            begin
                                slot_next    = '0;
                                outcome_next = OUTCOME_FULL;
                                state_next   = ST_DONE;
                            end
                        end
                    end
                end
            end
            ST_WRITE:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (done_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            cnt_reg       <= '0;
            chk_valid_reg <= 1'b0;
            have_free_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            chk_valid_reg <= chk_valid_next;
            have_free_reg <= have_free_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg   <= chk_idx_next;
        free_slot_reg <= free_slot_next;
        slot_reg      <= slot_next;
        outcome_reg   <= outcome_next;
    end

    assign slot_wide   = 32'(slot_reg);
    assign idle        = (state_reg == ST_IDLE);
    assign done_valid  = (state_reg == ST_DONE);
    assign rsp.outcome = outcome_reg;
    assign rsp.slot    = slot_wide[SLOT_W-1:0];

endmodule

/* hw/rtl/udp_flow_table_ttl.sv */
// Top level of the UDP flow table with per-session expiry.
//
// Input channel (in_valid/in_ready) carries one beat per packet: action,
// source_address, source_port and time_now. A lookup beat refreshes a live
// matching session or claims the first empty or expired slot; a clear beat
// drops every session. Each beat yields one result beat on the output
// channel (out_valid/out_ready) with outcome and slot_index.
// A lookup scans the single session memory one read per cycle and stops
// early on a hit; a clear writes every slot empty in turn.
// A new beat is accepted only after the previous one has left the sequencer.
// The result sits in an output register, so the next beat is accepted while
// the receiver stalls; a second result then waits until that register frees.
// After reset the sequencer sweeps the memory to drop all sessions; in_ready
// stays low during the sweep. The timeout register resets to 30 and is
// written with one cfg beat at any time.
module udp_flow_table_ttl #(
    parameter int TABLE_ENTRIES = uft_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           action,
    input  logic [31:0]                    source_address,
    input  logic [15:0]                    source_port,
    input  logic [31:0]                    time_now,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [uft_pkg::OUTCOME_W-1:0]  outcome,
    output logic [uft_pkg::SLOT_W-1:0]     slot_index,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [uft_pkg::TIMEOUT_W-1:0]  cfg_data
);
    import uft_pkg::*;

    logic [TIMEOUT_W-1:0] timeout_reg, timeout_next;
    logic                 out_valid_reg, out_valid_next;
    rsp_t                 out_reg;

    logic start;
    req_t req;
    logic idle;
    logic done_valid;
    logic done_ready;
    rsp_t rsp;

    assign cfg_ready    = 1'b1;
    assign timeout_next = (cfg_valid && cfg_ready) ? cfg_data : timeout_reg;

    assign in_ready    = idle;
    assign start       = in_valid && in_ready;
    assign req.clear   = action;
    assign req.address = source_address;
    assign req.port    = source_port;
    assign req.now     = time_now;
    assign req.fresh   = time_now + 32'(timeout_reg);

    uft_scan #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (req),
        .idle      (idle),
        .done_valid(done_valid),
        .done_ready(done_ready),
        .rsp       (rsp)
    );

    assign done_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (done_valid && done_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg   <= TIMEOUT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            timeout_reg   <= timeout_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_valid && done_ready)
        begin
            out_reg <= rsp;
        end
    end

    assign out_valid  = out_valid_reg;
    assign outcome    = out_reg.outcome;
    assign slot_index = out_reg.slot;

endmodule

/* hw/rtl/uft_check.sv */
// Port-level checks of the UDP flow table, bound to the top level.
module uft_check (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [uft_pkg::OUTCOME_W-1:0] outcome,
    input logic [uft_pkg::SLOT_W-1:0]    slot_index
);
    import uft_pkg::*;

    // A stalled result beat stays up.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    // A stalled result beat keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(outcome) && $stable(slot_index))
        else $error("result payload changed while stalled");

    // Full and cleared results carry slot zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (outcome == OUTCOME_FULL || outcome == OUTCOME_CLEARED)
        |-> slot_index == '0)
        else $error("nonzero slot on full or cleared result");

    // The sequencer is busy right after it takes a beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while sequencer busy");

endmodule

bind udp_flow_table_ttl uft_check u_uft_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .outcome   (outcome),
    .slot_index(slot_index)
);

/* tb/tb.sv */
// Self-checking testbench for the UDP flow table with per-session expiry.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import uft_pkg::*;

    localparam int TABLE_ENTRIES = TABLE_ENTRIES_DEF;
    localparam logic ACTION_LOOKUP = 1'b0;
    localparam logic ACTION_CLEAR = 1'b1;
    localparam int POOL_KEYS = 40;
    localparam int HOLD_OFF_CYCLES = 700;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic        action;
        logic [31:0] address;
        logic [15:0] port;
        logic [31:0] now;
    } packet_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic                 action;
    logic [31:0]          source_address;
    logic [15:0]          source_port;
    logic [31:0]          time_now;
    logic                 out_valid;
    logic                 out_ready;
    logic [OUTCOME_W-1:0] outcome;
    logic [SLOT_W-1:0]    slot_index;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [TIMEOUT_W-1:0] cfg_data;

    // Shadow copy of the session table and the timeout register.
    logic                 shadow_valid [TABLE_ENTRIES] = '{default: 1'b0};
    logic [31:0]          shadow_expiry [TABLE_ENTRIES] = '{default: 32'd0};
    logic [31:0]          shadow_addr [TABLE_ENTRIES] = '{default: 32'd0};
    logic [15:0]          shadow_port [TABLE_ENTRIES] = '{default: 16'd0};
    logic [TIMEOUT_W-1:0] timeout_shadow = TIMEOUT_RESET;

    rsp_t        replies_due [$];
    int          failures = 0;
    int          hold_off_requests = 0;
    int          burst_left = 0;
    bit          steady_sender = 1'b0;
    bit          offering = 1'b0;
    logic [31:0] pool_addr [POOL_KEYS];
    logic [15:0] pool_port [POOL_KEYS];

    udp_flow_table_ttl u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .source_address (source_address),
        .source_port    (source_port),
        .time_now       (time_now),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .outcome        (outcome),
        .slot_index     (slot_index),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic note_failure(input string msg);
        failures++;
        if (failures <= MAX_REPORTS)
        begin
            $display("%s", msg);
        end
    endtask

    // Computes the reply to one packet and updates the shadow table.
    function automatic rsp_t table_lookup(input packet_t pkt);
        rsp_t        reply;
        logic [31:0] fresh;
        logic        live;
        logic        found_free;
        int          free_slot;
        fresh = pkt.now + 32'(timeout_shadow);
        reply.outcome = OUTCOME_FULL;
        reply.slot = '0;
        found_free = 1'b0;
        free_slot = 0;
        if (pkt.action == ACTION_CLEAR)
        begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                shadow_valid[i] = 1'b0;
            end
            reply.outcome = OUTCOME_CLEARED;
            return reply;
        end
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            live = shadow_valid[i] && (shadow_expiry[i] >= pkt.now);
            if (live && shadow_addr[i] == pkt.address && shadow_port[i] == pkt.port)
            begin
                shadow_expiry[i] = fresh;
                reply.outcome = OUTCOME_HIT;
                reply.slot = i[SLOT_W-1:0];
                return reply;
            end
            if (!live && !found_free)
            begin
                found_free = 1'b1;
                free_slot = i;
            end
        end
        if (found_free)
        begin
            shadow_valid[free_slot] = 1'b1;
            shadow_expiry[free_slot] = fresh;
            shadow_addr[free_slot] = pkt.address;
            shadow_port[free_slot] = pkt.port;
            reply.outcome = OUTCOME_NEW;
            reply.slot = free_slot[SLOT_W-1:0];
        end
        return reply;
    endfunction

    // Every result beat is matched against the oldest outstanding reply.
    always @(posedge clk)
    begin : check_replies
        rsp_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            if (replies_due.size() == 0)
            begin
                note_failure($sformatf("unexpected result beat: outcome %0d slot %0d",
                                       outcome, slot_index));
            end
            else
            begin
                want = replies_due.pop_front();
                if (outcome !== want.outcome || slot_index !== want.slot)
                begin
                    note_failure($sformatf(
                        "mismatch: outcome exp %0d got %0d, slot exp %0d got %0d",
                        want.outcome, outcome, want.slot, slot_index));
                end
            end
        end
    end

    // The receiver runs its own mix of free-flowing, choppy and stalled stretches.
    initial
    begin : receiver
        int run_left;
        int hold_left;
        int served;
        int mode;
        run_left = 0;
        hold_left = 0;
        served = 0;
        mode = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (served != hold_off_requests)
            begin
                served = hold_off_requests;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                if (run_left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    run_left = (mode == 0) ? $urandom_range(50, 400) : $urandom_range(1, 40);
                end
                run_left--;
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= 1'($urandom_range(0, 1));
                    2: out_ready <= 1'b0;
                    default: out_ready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("udp_flow_table_ttl regression: fail");
        $finish;
    end

    task automatic lower_input();
        if (offering)
        begin
            in_valid <= 1'b0;
            offering = 1'b0;
        end
    endtask

    task automatic idle_input(input int cycles);
        lower_input();
        repeat (cycles) @(posedge clk);
    endtask

    // Offers one beat and records its reply once the beat is taken.
    task automatic send_packet(input packet_t pkt);
        in_valid <= 1'b1;
        offering = 1'b1;
        action <= pkt.action;
        source_address <= pkt.address;
        source_port <= pkt.port;
        time_now <= pkt.now;
        @(posedge clk);
        while (in_ready !== 1'b1) @(posedge clk);
        replies_due.push_back(table_lookup(pkt));
    endtask

    task automatic pace_sender();
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = $urandom_range(0, 9);
            if (!steady_sender && $urandom_range(0, 1) == 1)
            begin
                idle_input($urandom_range(1, 180));
            end
        end
    endtask

    task automatic send_lookup(input logic [31:0] addr, input logic [15:0] port,
                               input logic [31:0] now);
        packet_t pkt;
        pkt.action = ACTION_LOOKUP;
        pkt.address = addr;
        pkt.port = port;
        pkt.now = now;
        send_packet(pkt);
        pace_sender();
    endtask

    // Key and time fields of a clear beat carry noise; the block must ignore them.
    task automatic send_clear();
        packet_t pkt;
        pkt.action = ACTION_CLEAR;
        pkt.address = $urandom();
        pkt.port = 16'($urandom_range(0, 16'hFFFF));
        pkt.now = $urandom();
        send_packet(pkt);
        pace_sender();
    endtask

    task automatic wait_drained();
        lower_input();
        while (replies_due.size() != 0) @(posedge clk);
    endtask

    task automatic write_timeout(input logic [TIMEOUT_W-1:0] seconds);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data <= seconds;
        @(posedge clk);
        while (cfg_ready !== 1'b1) @(posedge clk);
        timeout_shadow = seconds;
        cfg_valid <= 1'b0;
    endtask

    task automatic reseed_pool();
        for (int i = 0; i < POOL_KEYS; i++)
        begin
            pool_addr[i] = $urandom();
            pool_port[i] = 16'($urandom_range(0, 16'hFFFF));
        end
    endtask

    // Runs at the reset timeout: claim, hit, expired matches and clear.
    task automatic test_lookup_basics();
        send_lookup(32'h0A00_0001, 16'd1000, 32'd100);
        send_lookup(32'h0A00_0001, 16'd1000, 32'd120);
        send_lookup(32'h0A00_0001, 16'd1001, 32'd120);
        send_lookup(32'h0000_0000, 16'h0000, 32'd120);
        send_lookup(32'hFFFF_FFFF, 16'hFFFF, 32'd120);
        // Expiry equal to the current time still counts as live.
        send_lookup(32'h0A00_0001, 16'd1000, 32'd150);
        // The expired match is itself the first free slot.
        send_lookup(32'h0A00_0001, 16'd1001, 32'd151);
        // Here an earlier expired slot wins over the expired match.
        send_lookup(32'hFFFF_FFFF, 16'hFFFF, 32'd151);
        send_clear();
        send_lookup(32'h0A00_0001, 16'd1000, 32'd160);
    endtask

    task automatic test_timeout_extremes();
        // A zero timeout keeps an entry live only within the same second.
        write_timeout(16'd0);
        send_clear();
        send_lookup(32'hC0A8_0101, 16'd53, 32'd500);
        send_lookup(32'hC0A8_0101, 16'd53, 32'd500);
        send_lookup(32'hC0A8_0101, 16'd53, 32'd501);
        // The largest timeout near the top of time makes the expiry wrap.
        write_timeout(16'hFFFF);
        send_clear();
        send_lookup(32'h7F00_0001, 16'd8080, 32'hFFFF_FFF0);
        send_lookup(32'h7F00_0001, 16'd8080, 32'hFFFF_FFF0);
        send_lookup(32'h7F00_0001, 16'd8080, 32'h0000_0010);
        send_lookup(32'h8000_0000, 16'h8000, 32'hFFFF_FFFF);
        write_timeout(16'd1);
        send_lookup(32'hC0A8_0101, 16'd53, 32'd7);
        send_lookup(32'hC0A8_0101, 16'd53, 32'd8);
        send_lookup(32'hC0A8_0101, 16'd53, 32'd10);
    endtask

    // Fills every slot, overflows, then lets part of the table age out.
    task automatic test_table_full();
        logic [31:0] fill_addr [TABLE_ENTRIES];
        logic [15:0] fill_port [TABLE_ENTRIES];
        logic [31:0] t0;
        int          pick;
        write_timeout(16'd1000);
        t0 = $urandom_range(0, 32'hF000_0000);
        send_clear();
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            fill_addr[i] = $urandom();
            fill_port[i] = 16'($urandom_range(0, 16'hFFFF));
            send_lookup(fill_addr[i], fill_port[i], t0 + i / 16);
        end
        for (int i = 0; i < 4; i++)
        begin
            send_lookup($urandom(), 16'($urandom_range(0, 16'hFFFF)), t0 + 10);
        end
        for (int i = 0; i < 40; i++)
        begin
            pick = $urandom_range(0, TABLE_ENTRIES - 1);
            send_lookup(fill_addr[pick], fill_port[pick], t0 + 500 + i);
        end
        for (int i = 0; i < 30; i++)
        begin
            send_lookup($urandom(), 16'($urandom_range(0, 16'hFFFF)), t0 + 1100);
        end
        for (int i = 0; i < 40; i++)
        begin
            pick = $urandom_range(0, TABLE_ENTRIES - 1);
            if ($urandom_range(0, 1) == 1)
            begin
                send_lookup(fill_addr[pick], fill_port[pick], t0 + 1100 + 40 * i);
            end
            else
            begin
                send_lookup($urandom(), 16'($urandom_range(0, 16'hFFFF)),
                            t0 + 1100 + 40 * i);
            end
        end
    endtask

    // The receiver holds off while the sender keeps offering beats.
    task automatic test_backpressure();
        wait_drained();
        reseed_pool();
        steady_sender = 1'b1;
        hold_off_requests++;
        for (int i = 0; i < 8; i++)
        begin
            send_lookup(pool_addr[i % 4], pool_port[i % 4], 32'd5000 + i);
        end
        wait_drained();
        steady_sender = 1'b0;
    endtask

    task automatic test_random_traffic(input logic [TIMEOUT_W-1:0] seconds, input int count);
        logic [31:0] now_s;
        int          pick;
        int          key;
        int          tpick;
        write_timeout(seconds);
        reseed_pool();
        now_s = $urandom_range(0, 32'hFFF0_0000);
        steady_sender = ($urandom_range(0, 3) == 0);
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            tpick = $urandom_range(0, 99);
            if (tpick < 8)
            begin
                now_s = $urandom();
            end
            else if (tpick < 12)
            begin
                now_s = 32'hFFFF_FFFF - $urandom_range(0, 2 * int'(seconds) + 4);
            end
            else
            begin
                now_s = now_s + $urandom_range(0, int'(seconds) / 8 + 2);
            end
            if (pick < 3)
            begin
                send_clear();
            end
            else if (pick < 70)
            begin
                key = $urandom_range(0, POOL_KEYS - 1);
                send_lookup(pool_addr[key], pool_port[key], now_s);
            end
            else
            begin
                send_lookup($urandom(), 16'($urandom_range(0, 16'hFFFF)), now_s);
            end
        end
        steady_sender = 1'b0;
    endtask

    initial
    begin : stimulus
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        action <= ACTION_LOOKUP;
        source_address <= '0;
        source_port <= '0;
        time_now <= '0;
        cfg_valid <= 1'b0;
        cfg_data <= TIMEOUT_RESET;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        test_lookup_basics();
        test_timeout_extremes();
        test_table_full();
        test_backpressure();
        test_random_traffic(16'd5, 135);
        test_random_traffic(16'd0, 135);
        test_random_traffic(16'hFFFF, 135);
        test_random_traffic(16'd1, 135);
        test_random_traffic(16'd30, 135);

        wait_drained();
        repeat (TABLE_ENTRIES + 8) @(posedge clk);
        if (replies_due.size() != 0)
        begin
            note_failure($sformatf("%0d results never arrived", replies_due.size()));
        end
        if (failures == 0)
        begin
            $display("udp_flow_table_ttl regression: pass");
        end
        else
        begin
            $display("udp_flow_table_ttl regression: fail");
        end
        $finish;
    end

endmodule
